@@ rtl/spiking_neuron_update_assert.svh @@
// Assertion macros shared by the checker; clock clk, reset arst_n.
`ifndef SPIKING_NEURON_UPDATE_ASSERT_SVH
`define SPIKING_NEURON_UPDATE_ASSERT_SVH

// Same-cycle implication.
`define SNU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("snu assertion failed");

// Next-cycle implication.
`define SNU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("snu assertion failed");

`endif

@@ rtl/snu_pkg.sv @@
`timescale 1ns / 1ps
package snu_pkg;

	typedef logic signed [31:0] q_t;

	localparam q_t QMAX = 32'sh7FFF_FFFF;
	localparam q_t QMIN = 32'sh8000_0000;

	// Euler substeps: count is a power of two, step division is a shift
	localparam int SUBST_LOG2  = 2;
	localparam int SUBST_COUNT = 1 << SUBST_LOG2;
	localparam int SUB_PHASES  = 10;

	// 2^32 / C, restoring division, up to two quotient bits per stage
	localparam int DIV_BITS    = 33;
	localparam int DIV_PER_STG = 2;
	localparam int DIV_STAGES  = (DIV_BITS + DIV_PER_STG - 1) / DIV_PER_STG;

	localparam int ST_CUR  = 1;
	localparam int ST_DIV0 = 2;
	localparam int ST_INV  = ST_DIV0 + DIV_STAGES;
	localparam int ST_SUB0 = ST_INV + 1;
	localparam int ST_FIN  = ST_SUB0 + SUBST_COUNT * SUB_PHASES;
	localparam int NSTAGE  = ST_FIN + 1;

	localparam int IN_DATA_W  = 352;
	localparam int OUT_DATA_W = 136;
	localparam int OUT_SPK    = 64;
	localparam int OUT_HIST_L = 65;
	localparam int OUT_HIST_H = 128;

	localparam int CFG_COUNT = 8;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A    = 3'd0,
		REG_B    = 3'd1,
		REG_C    = 3'd2,
		REG_D    = 3'd3,
		REG_PEAK = 3'd4,
		REG_VR   = 3'd5,
		REG_VT   = 3'd6,
		REG_VB   = 3'd7
	} cfg_idx_t;

	localparam q_t CFG_RESET [CFG_COUNT] = '{
		32'sd13107, 32'sd1638, -32'sd2949120, 32'sd0,
		32'sd1638400, -32'sd3604480, -32'sd2621440, -32'sd3604480
	};

	typedef struct packed {
		q_t a, b, c, d, peak, vr, vt, vb;
	} cfg_t;

	typedef struct packed {
		q_t          v, u, cur, ext, nm, k;
		q_t          kv, dvt, t, br, p, vn, w, bw, bww, cx, au, inv_c;
		logic        ge, fired, forced;
		logic [30:0] cap;
		logic [32:0] rem, quo;
		logic [63:0] hist;
	} item_t;

	function automatic q_t qsat(input logic signed [63:0] x);
		if (x > 64'(QMAX))
			return QMAX;
		else if (x < 64'(QMIN))
			return QMIN;
		else
			return x[31:0];
	endfunction

	function automatic q_t qadd(input q_t x, input q_t y);
		logic signed [63:0] s;
		s = 64'(x) + 64'(y);
		return qsat(s);
	endfunction

	function automatic q_t qsub(input q_t x, input q_t y);
		logic signed [63:0] s;
		s = 64'(x) - 64'(y);
		return qsat(s);
	endfunction

	// Q16.16 product, floor
	function automatic q_t qmul(input q_t x, input q_t y);
		logic signed [63:0] p;
		p = 64'(x) * 64'(y);
		return qsat(p >>> 16);
	endfunction

endpackage

@@ rtl/spiking_neuron_update.sv @@
`timescale 1ns / 1ps
// Throughput: one neuron per cycle; a stall on the master side freezes every stage.
// Depth is set by 17 division stages for 1/C and 4 substeps of 10 stages each.
// Reset (arst_n low, asynchronous): all stage valid bits clear, config
// registers take their default Q16.16 values.
module spiking_neuron_update import snu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]           cfg_data,
	// tdata: potential, recovery, excit_current, inhib_current, extern_current,
	//        noise_sample, noise_scale, gain_k, capacitance, forced_fire, fire_history
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// tdata: next_potential, next_recovery, spiked, next_history, zero pad
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	q_t    cfg_q [CFG_COUNT];
	cfg_t  cfg;
	logic  adv;

	logic  [NSTAGE-1:0] vld_s;
	item_t pipe_s [NSTAGE];
	item_t nxt    [NSTAGE];

	// Group parameters; the user must write them only while the pipeline is empty, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_COUNT; i++)
				cfg_q[i] <= CFG_RESET[i];
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	assign cfg.a    = cfg_q[REG_A];
	assign cfg.b    = cfg_q[REG_B];
	assign cfg.c    = cfg_q[REG_C];
	assign cfg.d    = cfg_q[REG_D];
	assign cfg.peak = cfg_q[REG_PEAK];
	assign cfg.vr   = cfg_q[REG_VR];
	assign cfg.vt   = cfg_q[REG_VT];
	assign cfg.vb   = cfg_q[REG_VB];

	// Whole pipe moves together; it stops only while the output holds a result that the master side does not take
	assign adv           = !vld_s[NSTAGE-1] || m_axis_tready;
	assign s_axis_tready = adv;

	// Up to two quotient bits of 2^32 / cap (the last stage has one)
	function automatic item_t f_div(input item_t it, input int stp);
		item_t       o;
		logic [32:0] r;
		int          bitn;
		o = it;
		for (int j = 0; j < DIV_PER_STG; j++) begin
			bitn = DIV_BITS - 1 - stp * DIV_PER_STG - j;
			if (bitn >= 0) begin
				r = {o.rem[31:0], (bitn == DIV_BITS - 1)};
				if (r >= {2'b00, o.cap}) begin
					r = r - {2'b00, o.cap};
					o.quo[bitn] = 1'b1;
				end
				o.rem = r;
			end
		end
		return o;
	endfunction

	// One phase of one Euler substep
	function automatic item_t f_sub(input item_t it, input int ph, input cfg_t c);
		item_t o;
		o = it;
		case (ph)
			0: begin
				o.dvt = qsub(it.v, c.vt);
				o.kv  = qmul(it.k, qsub(it.v, c.vr));
			end
			1: o.t = qmul(it.kv, it.dvt);
			2: begin
				o.br = qadd(qsub(it.t, it.u), it.cur);
				o.au = qmul(c.a, it.u);
			end
			3: o.p = qmul(it.inv_c, it.br);
			4: begin
				o.vn = qadd(it.v, it.p >>> SUBST_LOG2);
				o.ge = (o.vn >= c.vb);
				o.w  = qsub(o.vn, c.vb);
			end
			5: o.bw  = qmul(c.b, it.w);
			6: o.bww = qmul(it.bw, it.w);
			7: o.cx  = qmul(it.bww, it.w);
			8: o.cx  = qmul(c.a, qsub(it.cx, it.u));
			9: begin
				// once fired, later substeps leave v and u alone
				if (!it.fired) begin
					o.v     = it.vn;
					o.u     = it.ge ? qadd(it.u, it.cx >>> SUBST_LOG2)
					                : qsub(it.u, it.au >>> SUBST_LOG2);
					o.fired = (it.vn >= c.peak);
				end
			end
			default: o = it;
		endcase
		return o;
	endfunction

	// Entry: unpack, first current add, noise product
	always_comb begin
		nxt[0]        = '0;
		nxt[0].v      = s_axis_tdata[31:0];
		nxt[0].u      = s_axis_tdata[63:32];
		nxt[0].cur    = qadd(q_t'(s_axis_tdata[95:64]), q_t'(s_axis_tdata[127:96]));
		nxt[0].ext    = s_axis_tdata[159:128];
		nxt[0].nm     = qmul(q_t'(s_axis_tdata[223:192]), q_t'(s_axis_tdata[191:160]));
		nxt[0].k      = s_axis_tdata[255:224];
		nxt[0].cap    = s_axis_tdata[286:256];
		nxt[0].forced = s_axis_tdata[287];
		nxt[0].hist   = s_axis_tdata[351:288];
	end

	for (genvar i = 1; i < NSTAGE; i++) begin : g_stage
		if (i == ST_CUR) begin : g_cur
			always_comb begin
				nxt[i]     = pipe_s[i-1];
				nxt[i].cur = qadd(qadd(pipe_s[i-1].cur, pipe_s[i-1].ext), pipe_s[i-1].nm);
			end
		end else if (i < ST_INV) begin : g_div
			always_comb nxt[i] = f_div(pipe_s[i-1], i - ST_DIV0);
		end else if (i == ST_INV) begin : g_inv
			always_comb begin
				nxt[i]       = pipe_s[i-1];
				nxt[i].inv_c = (pipe_s[i-1].quo[32:31] != 2'b00) ? QMAX
				               : q_t'(pipe_s[i-1].quo[31:0]);
			end
		end else if (i < ST_FIN) begin : g_sub
			always_comb nxt[i] = f_sub(pipe_s[i-1], (i - ST_SUB0) % SUB_PHASES, cfg);
		end else begin : g_fin
			always_comb begin
				nxt[i]       = pipe_s[i-1];
				nxt[i].fired = pipe_s[i-1].fired | pipe_s[i-1].forced;
				nxt[i].hist  = {pipe_s[i-1].hist[62:0], nxt[i].fired};
				if (nxt[i].fired) begin
					nxt[i].v = cfg.c;
					nxt[i].u = qadd(pipe_s[i-1].u, cfg.d);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTAGE-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < NSTAGE; i++)
				pipe_s[i] <= nxt[i];
		end
	end

	assign m_axis_tvalid = vld_s[NSTAGE-1];
	assign m_axis_tdata  = {7'd0, pipe_s[NSTAGE-1].hist, pipe_s[NSTAGE-1].fired,
	                        pipe_s[NSTAGE-1].u, pipe_s[NSTAGE-1].v};

endmodule

@@ rtl/snu_checker.sv @@
`timescale 1ns / 1ps
`include "spiking_neuron_update_assert.svh"
module snu_checker import snu_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	`SNU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`SNU_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`SNU_ASSERT_NOW(a_hist_lsb, m_axis_tvalid, m_axis_tdata[OUT_HIST_L] == m_axis_tdata[OUT_SPK])
	`SNU_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_DATA_W-1:OUT_HIST_H+1] == '0)
	`SNU_ASSERT_NOW(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

bind spiking_neuron_update snu_checker u_snu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

@@ dv/spiking_neuron_update_tb.sv @@
`timescale 1ns / 1ps
module spiking_neuron_update_tb;
	import snu_pkg::*;

	// one neuron update as it travels on the slave side
	typedef struct {
		q_t          v, u, exc, inh, ext, noise, sigma, k;
		logic [30:0] cap;
		logic        forced;
		logic [63:0] hist;
	} neuron_t;

	// one updated neuron as it leaves on the master side
	typedef struct {
		q_t          v, u;
		logic        spiked;
		logic [63:0] hist;
	} update_t;

	localparam int STALL_LIMIT = 5000;  // cycles with no transfer before giving up
	localparam int DRAIN_WAIT  = 80;    // a little over the pipeline depth
	localparam int LONG_HOLD   = 400;   // receiver hold-off, well past the pipeline depth

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [31:0]           cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// tdata: potential, recovery, excit_current, inhib_current, extern_current,
	//        noise_sample, noise_scale, gain_k, capacitance, forced_fire, fire_history
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// tdata: next_potential, next_recovery, spiked, next_history, zero pad
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// testbench copy of the group parameters
	q_t        group_cfg [CFG_COUNT];
	neuron_t   pending [$];     // updates waiting to be offered
	neuron_t   on_bus;          // update currently offered
	update_t   expected_upd [$];
	int        errors = 0;
	bit        steady = 1'b0;   // phase with no random gaps or stalls on either side
	bit        stim_done = 1'b0;

	spiking_neuron_update i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---- saturating Q16.16 arithmetic for the predictor ----
	function automatic q_t clamp(input logic signed [63:0] x);
		if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (x < -64'sh8000_0000) return 32'sh8000_0000;
		return x[31:0];
	endfunction

	function automatic q_t fx_add(input q_t x, input q_t y);
		return clamp(64'(x) + 64'(y));
	endfunction

	function automatic q_t fx_sub(input q_t x, input q_t y);
		return clamp(64'(x) - 64'(y));
	endfunction

	// product floors: arithmetic shift of the full 64-bit product
	function automatic q_t fx_mul(input q_t x, input q_t y);
		logic signed [63:0] p;
		p = 64'(x) * 64'(y);
		return clamp(p >>> 16);
	endfunction

	// Euler step division by four, floor
	function automatic q_t quarter(input q_t x);
		return x >>> 2;
	endfunction

	// Full neuron step: current, 1/C, four substeps, spike and reset
	function automatic update_t neuron_step(input neuron_t n);
		update_t            r;
		q_t                 v, u, cur, inv_c, t, br, w, cube;
		logic signed [63:0] capw;
		logic               fired;
		v = n.v;
		u = n.u;
		fired = 1'b0;
		cur = fx_add(fx_add(n.exc, n.inh), n.ext);
		if (n.sigma != 0)
			cur = fx_add(cur, fx_mul(n.sigma, n.noise));
		capw = {33'd0, n.cap};
		if (n.cap == 0)
			inv_c = 32'sh7FFF_FFFF;  // zero capacitance saturates the reciprocal
		else
			inv_c = clamp(64'sh1_0000_0000 / capw);
		for (int s = 0; s < SUBST_COUNT; s++) begin
			if (!fired) begin
				t  = fx_mul(fx_mul(n.k, fx_sub(v, group_cfg[REG_VR])),
					fx_sub(v, group_cfg[REG_VT]));
				br = fx_add(fx_sub(t, u), cur);
				v  = fx_add(v, quarter(fx_mul(inv_c, br)));
				if (v >= group_cfg[REG_VB]) begin
					// cubic recovery above the bend
					w    = fx_sub(v, group_cfg[REG_VB]);
					cube = fx_mul(fx_mul(fx_mul(group_cfg[REG_B], w), w), w);
					u    = fx_add(u, quarter(fx_mul(group_cfg[REG_A], fx_sub(cube, u))));
				end else begin
					u = fx_sub(u, quarter(fx_mul(group_cfg[REG_A], u)));
				end
				fired = (v >= group_cfg[REG_PEAK]);
			end
		end
		fired = fired | n.forced;
		r.hist = {n.hist[62:0], fired};
		if (fired) begin
			v = group_cfg[REG_C];
			u = fx_add(u, group_cfg[REG_D]);
		end
		r.v = v;
		r.u = u;
		r.spiked = fired;
		return r;
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_neuron(input neuron_t n);
		return {n.hist, n.forced, n.cap, n.k, n.sigma, n.noise, n.ext, n.inh, n.exc,
			n.u, n.v};
	endfunction

	function automatic q_t rnd32();
		return $urandom();
	endfunction

	// small signed value, magnitude up to mag whole units
	function automatic q_t rnd_units(input int mag);
		return $signed($urandom_range(0, 2 * mag * 65536)) - mag * 65536;
	endfunction

	// fully random content in every bit of every field, but sigma is zero one time in four
	function automatic neuron_t wild_neuron();
		neuron_t n;
		n.v = rnd32(); n.u = rnd32(); n.exc = rnd32(); n.inh = rnd32();
		n.ext = rnd32(); n.noise = rnd32(); n.sigma = rnd32(); n.k = rnd32();
		n.cap = 31'($urandom()); n.forced = 1'($urandom()); n.hist = {$urandom(), $urandom()};
		if ($urandom_range(0, 3) == 0) n.sigma = 0;
		return n;
	endfunction

	// physiological ranges so the substeps actually integrate and spike
	function automatic neuron_t plausible_neuron();
		neuron_t n;
		n.v      = rnd_units(80);
		n.u      = rnd_units(40);
		n.exc    = $urandom_range(0, 600 * 65536);
		n.inh    = -$signed($urandom_range(0, 200 * 65536));
		n.ext    = rnd_units(100);
		n.noise  = rnd_units(3);
		n.sigma  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 20 * 65536);
		n.k      = $urandom_range(0, 2 * 65536);
		n.cap    = 31'($urandom_range(1, 100 * 65536));
		n.forced = ($urandom_range(0, 9) == 0);
		n.hist   = {$urandom(), $urandom()};
		return n;
	endfunction

	// ---- sender: bursts with random gaps ----
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		logic give;
		if (s_axis_tvalid && s_axis_tready)
			expected_upd.push_back(neuron_step(on_bus));
		give = 1'b0;
		if (s_axis_tvalid && !s_axis_tready) begin
			give = 1'b1;  // hold the offer until it is taken
		end else if (gap_left > 0 && !steady) begin
			gap_left <= gap_left - 1;
		end else if (pending.size() > 0) begin
			give = 1'b1;
			on_bus = pending.pop_front();
			s_axis_tdata <= pack_neuron(on_bus);
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 30);
				gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			end else begin
				burst_left <= burst_left - 1;
			end
		end
		s_axis_tvalid <= give;
	end

	// ---- receiver: own stall pattern plus one long hold-off ----
	int rx_count = 0;
	int hold_left = 0;
	bit held_once = 1'b0;
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			rx_count <= rx_count + 1;
		if (!held_once && rx_count == 150) begin
			// stop draining long enough for the pipeline to back up into the input
			held_once <= 1'b1;
			hold_left <= LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (steady) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) < 70);
		end
	end

	// ---- result check ----
	always @(posedge clk) begin
		update_t exp_u;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_upd.size() == 0) begin
				$error("unexpected result transfer, tdata %h", m_axis_tdata);
				errors++;
			end else begin
				exp_u = expected_upd.pop_front();
				if (m_axis_tdata[31:0] !== exp_u.v) begin
					$error("next_potential: expected %h, got %h", exp_u.v, m_axis_tdata[31:0]);
					errors++;
				end
				if (m_axis_tdata[63:32] !== exp_u.u) begin
					$error("next_recovery: expected %h, got %h", exp_u.u, m_axis_tdata[63:32]);
					errors++;
				end
				if (m_axis_tdata[OUT_SPK] !== exp_u.spiked) begin
					$error("spiked: expected %b, got %b", exp_u.spiked, m_axis_tdata[OUT_SPK]);
					errors++;
				end
				if (m_axis_tdata[OUT_HIST_H:OUT_HIST_L] !== exp_u.hist) begin
					$error("next_history: expected %h, got %h", exp_u.hist,
						m_axis_tdata[OUT_HIST_H:OUT_HIST_L]);
					errors++;
				end
			end
		end
	end

	// ---- watchdog: cycles without any transfer ----
	int quiet = 0;
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || stim_done)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// one write per call; the enable drops at the following edge, so calls in a row
	// never schedule two updates of it in one time step
	task automatic write_reg(input cfg_idx_t idx, input q_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		group_cfg[idx] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// waits until every queued update is sent and every expected update is back, then lets the pipe drain
	task automatic wait_idle();
		wait (pending.size() == 0 && !s_axis_tvalid && expected_upd.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic queue_random(input int count);
		for (int i = 0; i < count; i++)
			pending.push_back(($urandom_range(0, 3) == 0) ? wild_neuron() : plausible_neuron());
	endtask

	initial begin
		neuron_t n;
		foreach (group_cfg[i]) group_cfg[i] = CFG_RESET[i];
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, forced fire, zero capacitance, noise off, bend sides
		n = plausible_neuron();
		n.v = 32'sh7FFF_FFFF; n.u = 32'sh7FFF_FFFF; n.exc = 32'sh7FFF_FFFF;
		n.inh = 32'sh7FFF_FFFF; n.ext = 32'sh7FFF_FFFF; n.noise = 32'sh7FFF_FFFF;
		n.sigma = 32'sh7FFF_FFFF; n.k = 32'sh7FFF_FFFF; n.cap = '1; n.forced = 1'b1;
		n.hist = '1;
		pending.push_back(n);
		n.v = 32'sh8000_0000; n.u = 32'sh8000_0000; n.exc = 32'sh8000_0000;
		n.inh = 32'sh8000_0000; n.ext = 32'sh8000_0000; n.noise = 32'sh8000_0000;
		n.sigma = 32'sh8000_0000; n.k = 32'sh8000_0000; n.cap = 31'd1; n.forced = 1'b0;
		n.hist = '0;
		pending.push_back(n);
		n = '{default: 0};
		pending.push_back(n);  // zero capacitance, everything else zero
		for (int i = 0; i < 6; i++) begin
			n = plausible_neuron();
			n.cap = 31'(20 * 65536);
			n.k = 65536;
			n.v = (i < 3) ? -70 * 65536 : -55 * 65536;  // below and at the bend
			n.exc = (i % 3) * 300 * 65536;               // none, moderate, strong drive
			n.sigma = 0;
			n.forced = (i == 1);
			pending.push_back(n);
		end
		n = plausible_neuron(); n.cap = '0; pending.push_back(n);
		n = plausible_neuron(); n.v = 40 * 65536; n.forced = 1'b0; pending.push_back(n);
		wait_idle();

		// reset defaults, random traffic
		queue_random(100);
		wait_idle();

		// a fresh parameter group, nonzero recovery jump
		write_reg(REG_A, 6554);
		write_reg(REG_B, 13107);
		write_reg(REG_C, -50 * 65536);
		write_reg(REG_D, 2 * 65536);
		write_reg(REG_PEAK, 30 * 65536);
		write_reg(REG_VR, -60 * 65536);
		write_reg(REG_VT, -40 * 65536);
		write_reg(REG_VB, -55 * 65536);
		steady = 1'b1;
		queue_random(80);
		wait_idle();
		steady = 1'b0;

		// all registers at the positive extreme
		for (int i = 0; i < CFG_COUNT; i++) write_reg(cfg_idx_t'(i), 32'sh7FFF_FFFF);
		queue_random(40);
		wait_idle();

		// all registers at the negative extreme
		for (int i = 0; i < CFG_COUNT; i++) write_reg(cfg_idx_t'(i), 32'sh8000_0000);
		queue_random(40);
		wait_idle();

		// fully random group parameters
		for (int i = 0; i < CFG_COUNT; i++) write_reg(cfg_idx_t'(i), rnd32());
		queue_random(40);
		wait_idle();

		// back to the default group for the last stretch
		for (int i = 0; i < CFG_COUNT; i++) write_reg(cfg_idx_t'(i), CFG_RESET[i]);
		queue_random(100);
		wait_idle();

		stim_done = 1'b1;
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ spiking_neuron_update.f @@
+incdir+rtl
rtl/snu_pkg.sv
rtl/spiking_neuron_update.sv
rtl/snu_checker.sv
dv/spiking_neuron_update_tb.sv
